>>> hw/rtl/sopg_pkg.sv
package sopg_pkg;

  localparam int COORD_BITS    = 16;
  localparam int SIDE_BITS     = 14;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (COORD_BITS > SIDE_BITS) ? COORD_BITS : SIDE_BITS;
  // wide enough for corner + side and for corner + 1 without wrapping
  localparam int EXT_BITS = ((COORD_BITS > SIDE_BITS) ? COORD_BITS : SIDE_BITS + 1) + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [SIDE_BITS-1:0]  side_t;

  typedef enum logic [1:0] {
    SHAPE_VERT  = 2'd0,
    SHAPE_HORIZ = 2'd1,
    SHAPE_DIAG  = 2'd2,
    SHAPE_RECT  = 2'd3
  } shape_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SHAPE_KIND  = 3'd0,
    REG_START_X     = 3'd1,
    REG_START_Y     = 3'd2,
    REG_END_X       = 3'd3,
    REG_END_Y       = 3'd4,
    REG_RECT_WIDTH  = 3'd5,
    REG_RECT_HEIGHT = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    shape_e shape_kind;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    side_t  rect_width;
    side_t  rect_height;
  } cfg_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

endpackage

>>> hw/rtl/sopg_if.sv
// Step request channel
interface sopg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

// Outline point channel
interface sopg_pt_if import sopg_pkg::*;;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   is_last;

  modport source (output valid, output point_x, output point_y, output is_last, input ready);
  modport sink   (input valid, input point_x, input point_y, input is_last, output ready);
endinterface

// Register write channel
interface sopg_cfg_if import sopg_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/shape_outline_point_generator.sv
// Throughput: one word per cycle while pt_o.ready is high; a two-stage pipeline
// (point select, then last-point check) with ready passed back through both
// stages. Reset (rst_ni low, async): registers but the output word (point,
// is_last) cleared to 0, walk position (0,0), walk not started so the first
// request returns the start point.
module shape_outline_point_generator import sopg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sopg_cfg_if.sink   cfg_i,
  sopg_req_if.sink   req_i,
  sopg_pt_if.source  pt_o
);

  // One outline step from (cx, cy) under configuration c.
  // Any point that matches no rule falls back to the start point.
  function automatic point_t advance(input cfg_t c, input coord_t cx, input coord_t cy);
    point_t                      n;
    logic signed [EXT_BITS-1:0]  cx_e;
    logic signed [EXT_BITS-1:0]  sx_e;
    logic signed [EXT_BITS-1:0]  sy_e;
    logic signed [EXT_BITS-1:0]  right_e;
    logic signed [EXT_BITS-1:0]  top_e;
    logic signed [EXT_BITS-1:0]  cmax_e;
    coord_t                      right;
    coord_t                      top;
    coord_t                      step_x;
    coord_t                      step_y;
    n.x    = c.start_x;
    n.y    = c.start_y;
    cmax_e = {{(EXT_BITS-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
    cx_e   = EXT_BITS'(cx);
    sx_e   = EXT_BITS'(c.start_x);
    sy_e   = EXT_BITS'(c.start_y);
    // far corner, saturated at the largest coordinate
    right_e = sx_e + $signed({{(EXT_BITS-SIDE_BITS){1'b0}}, c.rect_width});
    top_e   = sy_e + $signed({{(EXT_BITS-SIDE_BITS){1'b0}}, c.rect_height});
    right   = (right_e > cmax_e) ? cmax_e[COORD_BITS-1:0] : right_e[COORD_BITS-1:0];
    top     = (top_e > cmax_e) ? cmax_e[COORD_BITS-1:0] : top_e[COORD_BITS-1:0];
    step_x  = (c.end_x >= c.start_x) ? coord_t'(1) : coord_t'(-1);
    step_y  = (c.end_y >= c.start_y) ? coord_t'(1) : coord_t'(-1);
    case (c.shape_kind)
      SHAPE_VERT: begin
        if (!(cx == c.start_x && cy == c.end_y)) begin
          n.y = cy + step_y;
        end
      end
      SHAPE_HORIZ: begin
        if (!(cx == c.end_x && cy == c.start_y)) begin
          n.x = cx + step_x;
        end
      end
      SHAPE_DIAG: begin
        // unequal extents: wrap as soon as either axis hits its end
        if (!(cx == c.end_x || cy == c.end_y)) begin
          n.x = cx + step_x;
          n.y = cy + step_y;
        end
      end
      default: begin
        if (cx_e == sx_e + EXT_BITS'(1) && cy == c.start_y) begin
          n.x = c.start_x;
        end else if (cy < top && cx == c.start_x) begin
          n.x = cx;                              // up the left side
          n.y = cy + coord_t'(1);
        end else if (cy == top && cx < right) begin
          n.x = cx + coord_t'(1);                // across the top
          n.y = cy;
        end else if (cx == right && cy > c.start_y) begin
          n.x = cx;                              // down the right side
          n.y = cy - coord_t'(1);
        end else if (cx > c.start_x && cy == c.start_y) begin
          n.x = cx - coord_t'(1);                // back along the bottom
          n.y = cy;
        end
      end
    endcase
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers; writes always accepted, unknown index dropped
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SHAPE_KIND:  cfg_q.shape_kind  <= shape_e'(cfg_i.data[1:0]);
        REG_START_X:     cfg_q.start_x     <= cfg_i.data[COORD_BITS-1:0];
        REG_START_Y:     cfg_q.start_y     <= cfg_i.data[COORD_BITS-1:0];
        REG_END_X:       cfg_q.end_x       <= cfg_i.data[COORD_BITS-1:0];
        REG_END_Y:       cfg_q.end_y       <= cfg_i.data[COORD_BITS-1:0];
        REG_RECT_WIDTH:  cfg_q.rect_width  <= cfg_i.data[SIDE_BITS-1:0];
        REG_RECT_HEIGHT: cfg_q.rect_height <= cfg_i.data[SIDE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Stage 1 holds the walk position (cur_q), which is also the
  // point of the word in flight there; stage 2 is the output register.
  // ---------------------------------------------------------------------------
  logic   s1_valid_q;
  logic   out_valid_q;
  logic   started_q;
  point_t cur_q;
  point_t cur_d;
  point_t step_pt;
  point_t next_pt;
  logic   s2_ready;
  logic   s1_take;
  logic   req_take;

  assign s2_ready    = !out_valid_q || pt_o.ready;
  assign s1_take     = s1_valid_q && s2_ready;
  assign req_i.ready = !s1_valid_q || s2_ready;
  assign req_take    = req_i.valid && req_i.ready;

  // Stage 1: restart or first request goes to start, else one step on
  assign step_pt = advance(cfg_q, cur_q.x, cur_q.y);

  always_comb begin
    if (req_i.restart || !started_q) begin
      cur_d.x = cfg_q.start_x;
      cur_d.y = cfg_q.start_y;
    end else begin
      cur_d = step_pt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q      <= '0;
      started_q  <= 1'b0;
      s1_valid_q <= 1'b0;
    end else if (req_take) begin
      cur_q      <= cur_d;
      started_q  <= 1'b1;
      s1_valid_q <= 1'b1;
    end else if (s1_take) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Stage 2: last point when its successor is the start point
  assign next_pt = step_pt;

  coord_t out_x_q;
  coord_t out_y_q;
  logic   out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_take) begin
      out_valid_q <= 1'b1;
    end else if (pt_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_take) begin
      out_x_q    <= cur_q.x;
      out_y_q    <= cur_q.y;
      out_last_q <= (next_pt.x == cfg_q.start_x) && (next_pt.y == cfg_q.start_y);
    end
  end

  assign pt_o.valid   = out_valid_q;
  assign pt_o.point_x = out_x_q;
  assign pt_o.point_y = out_y_q;
  assign pt_o.is_last = out_last_q;

endmodule
